FILE: rtl/swlt_pkg.sv
// Package for the sliding window lane tracker: field widths, reset values,
// register indexes, payload structs and the control structs between modules.
// Depends on nothing; every other file of the block but swlt_stream_if imports it.
package swlt_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_WINDOWS_DEF = 12;
    localparam int COORD_BITS_DEF  = 12;

    // Fixed widths of the configuration registers and payload fields.
    localparam int WIDTH_BITS   = 12;
    localparam int HEIGHT_BITS  = 12;
    localparam int WINDOW_BITS  = 10;
    localparam int MARGIN_BITS  = WINDOW_BITS - 1;
    localparam int THRESH_BITS  = 10;
    localparam int DEFAULT_BITS = 12;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_VAL_BITS = 12;
    localparam int INDEX_BITS   = 4;
    localparam int OUT_BITS     = 12;
    localparam int COUNT_BITS   = 11;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Register reset values.
    localparam logic [WIDTH_BITS-1:0]   IMAGE_WIDTH_RST     = 12'd960;
    localparam logic [HEIGHT_BITS-1:0]  IMAGE_HEIGHT_RST    = 12'd720;
    localparam logic [WINDOW_BITS-1:0]  WINDOW_WIDTH_RST    = 10'd120;
    localparam logic [THRESH_BITS-1:0]  COUNT_THRESHOLD_RST = 10'd24;
    localparam logic [DEFAULT_BITS-1:0] RIGHT_DEFAULT_RST   = 12'd960;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_DEFAULT   = 3'd4;

    typedef struct packed {
        logic pixel_on;
        logic row_end;
        logic frame_start;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_BITS-1:0]      window_index;
        logic [OUT_BITS-1:0]        row_y;
        logic signed [OUT_BITS-1:0] left_x;
        logic signed [OUT_BITS-1:0] right_x;
        logic signed [OUT_BITS-1:0] mid_x;
        logic                       last_of_frame;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0] index;
        logic [CFG_VAL_BITS-1:0] value;
    } t_cfg_write;

    typedef struct packed {
        logic [WIDTH_BITS-1:0]   image_width;
        logic [HEIGHT_BITS-1:0]  image_height;
        logic [WINDOW_BITS-1:0]  search_width;
        logic [THRESH_BITS-1:0]  count_threshold;
        logic [DEFAULT_BITS-1:0] right_default;
    } t_cfg;

    // Per-pixel control for one side accumulator.
    typedef struct packed {
        logic advance;   // the pixel updates the state
        logic clear;     // frame start: treat the row accumulators as empty
        logic pixel;     // lit pixel
        logic init_row;  // seeding row: split by image half
        logic half_hit;  // pixel lies in this side's image half
        logic row_done;  // last pixel of the row: clear after use
    } t_acc_ctl;

    // Row status of one side, including the pixel now in work.
    typedef struct packed {
        logic found;
        logic move;      // found and count at or above threshold
        logic below;     // count below threshold
        logic above;     // count above threshold
    } t_side_stat;

endpackage

FILE: rtl/swlt_stream_if.sv
// Valid/ready channel with a typed payload, used for the pixel input,
// the result output and the configuration write channel.
// Depends on nothing; payload types come from swlt_pkg at instantiation.
interface swlt_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/sliding_window_lane_tracker.sv
// Top level of the sliding window lane tracker: configuration registers, input
// register, two side accumulators, centre update and result register.
// Depends on swlt_pkg, swlt_stream_if, swlt_cfg_regs, swlt_side_acc, swlt_center_upd.
//
//  Channel  Direction  Payload                                  Transaction
//  -------  ---------  ---------------------------------------  ----------------------
//  i_in     in         pixel_on, row_end, frame_start           one pixel
//  o_out    out        window_index, row_y, left_x, right_x,    one result per row
//                      mid_x, last_of_frame
//  i_cfg    in         index, value                             one register write
//
// One pixel is taken every cycle unless i_in is stalled. A pixel moves from the
// input register through the accumulators; a row-end pixel loads the result
// register as it leaves the input register, so a result passes the input register
// and then the result register. Only a row-end pixel meeting a full result register
// waits in the input register, which then stalls i_in; configuration writes are
// always taken. Reset is synchronous, active low, clears all tracking state at
// once (no clearing pass), and the derived window height is registered from the
// image_height register.
module sliding_window_lane_tracker #(
    parameter int NUM_WINDOWS = swlt_pkg::NUM_WINDOWS_DEF,
    parameter int COORD_BITS  = swlt_pkg::COORD_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    swlt_stream_if.sink   i_in,
    swlt_stream_if.source o_out,
    swlt_stream_if.sink   i_cfg
);
    import swlt_pkg::*;

    // Window counter must hold NUM_WINDOWS itself: that value marks a finished frame.
    localparam int WIN_BITS = $clog2(NUM_WINDOWS + 1);
    localparam logic [WIN_BITS-1:0] NUM_WIN  = WIN_BITS'(NUM_WINDOWS);
    localparam logic [WIN_BITS-1:0] LAST_WIN = WIN_BITS'(NUM_WINDOWS - 1);
    localparam int XW = ((COORD_BITS > WIDTH_BITS) ? COORD_BITS : WIDTH_BITS);
    localparam int RY_BITS = HEIGHT_BITS + WIN_BITS;

    t_cfg                   cfg;
    logic [HEIGHT_BITS-1:0] band_height;

    // Input register.
    logic     r_in_valid;
    t_in_item r_in;

    // Tracking state.
    logic [WIN_BITS-1:0]          r_win;
    logic [COORD_BITS-1:0]        r_col;
    logic signed [COORD_BITS-1:0] r_left_center, r_right_center;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic [WIN_BITS-1:0]          eff_k;
    logic [COORD_BITS-1:0]        x;
    logic                         active, init_row, left_half, produce, out_free;
    logic                         consume, advance, row_done, in_ready;
    t_acc_ctl                     l_ctl, r_ctl;
    t_side_stat                   l_stat, r_stat;
    logic signed [COORD_BITS-1:0] l_seed, r_seed, lc, rc, mid;
    logic [MARGIN_BITS-1:0]       margin;
    logic [RY_BITS-1:0]           k_wh, row_y_full;
    logic [HEIGHT_BITS-1:0]       half_wh_up;

    swlt_cfg_regs #(
        .NUM_WINDOWS (NUM_WINDOWS)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (i_cfg),
        .o_cfg         (cfg),
        .o_band_height (band_height)
    );

    // Frame start restarts at window 0 with empty accumulators, and the same
    // pixel counts as column 0.
    always_comb begin
        eff_k     = r_in.frame_start ? '0 : r_win;
        x         = r_in.frame_start ? '0 : r_col;
        active    = eff_k < NUM_WIN;
        init_row  = (eff_k == '0);
        margin    = cfg.search_width[WINDOW_BITS-1:1];
        left_half = XW'(x) < XW'(cfg.image_width[WIDTH_BITS-1:1]);

        // Past the final window pixels are dropped until the next frame start.
        produce  = r_in_valid && r_in.row_end && active;
        out_free = !r_out_valid || o_out.ready;
        consume  = r_in_valid && (!produce || out_free);
        advance  = consume && active;
        row_done = advance && r_in.row_end;
        in_ready = !r_in_valid || consume;

        l_ctl.advance  = advance;
        l_ctl.clear    = r_in.frame_start;
        l_ctl.pixel    = r_in.pixel_on;
        l_ctl.init_row = init_row;
        l_ctl.half_hit = left_half;
        l_ctl.row_done = row_done;

        r_ctl          = l_ctl;
        r_ctl.half_hit = !left_half;
    end

    swlt_side_acc #(
        .COORD_BITS (COORD_BITS)
    ) u_left (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (l_ctl),
        .i_x         (x),
        .i_center    (r_left_center),
        .i_margin    (margin),
        .i_threshold (cfg.count_threshold),
        .o_stat      (l_stat),
        .o_seed      (l_seed)
    );

    swlt_side_acc #(
        .COORD_BITS (COORD_BITS)
    ) u_right (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_ctl),
        .i_x         (x),
        .i_center    (r_right_center),
        .i_margin    (margin),
        .i_threshold (cfg.count_threshold),
        .o_stat      (r_stat),
        .o_seed      (r_seed)
    );

    swlt_center_upd #(
        .COORD_BITS (COORD_BITS)
    ) u_center (
        .i_init_row      (init_row),
        .i_lstat         (l_stat),
        .i_rstat         (r_stat),
        .i_lseed         (l_seed),
        .i_rseed         (r_seed),
        .i_left_center   (r_left_center),
        .i_right_center  (r_right_center),
        .i_right_default (cfg.right_default),
        .o_left          (lc),
        .o_right         (rc),
        .o_mid           (mid)
    );

    // Row centre: the midpoint of the window's low and high edges works out
    // to height - k*wh - ceil(wh/2), never negative for a valid window.
    always_comb begin
        half_wh_up = (band_height >> 1) + HEIGHT_BITS'(band_height[0]);
        k_wh       = RY_BITS'(eff_k) * RY_BITS'(band_height);
        row_y_full = RY_BITS'(cfg.image_height) - k_wh - RY_BITS'(half_wh_up);

        n_out.window_index  = INDEX_BITS'(eff_k);
        n_out.row_y         = row_y_full[OUT_BITS-1:0];
        n_out.left_x        = OUT_BITS'(lc);
        n_out.right_x       = OUT_BITS'(rc);
        n_out.mid_x         = OUT_BITS'(mid);
        n_out.last_of_frame = (eff_k == LAST_WIN);
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_win          <= '0;
            r_col          <= '0;
            r_left_center  <= '0;
            r_right_center <= '0;
        end else begin
            if (i_in.valid && in_ready) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end

            if (row_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (row_done) begin
                r_win          <= eff_k + 1'b1;
                r_col          <= '0;
                r_left_center  <= lc;
                r_right_center <= rc;
            end else if (advance) begin
                r_win <= eff_k;
                r_col <= x + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_in <= i_in.data;
        end
        if (row_done) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: rtl/swlt_cfg_regs.sv
// Configuration registers and the derived window height.
// Depends on swlt_pkg and swlt_stream_if.
module swlt_cfg_regs #(
    parameter int NUM_WINDOWS = swlt_pkg::NUM_WINDOWS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    swlt_stream_if.sink                        i_cfg,
    output swlt_pkg::t_cfg                     o_cfg,
    output logic [swlt_pkg::HEIGHT_BITS-1:0]   o_band_height
);
    import swlt_pkg::*;

    // Exact reciprocal for height / NUM_WINDOWS over every 12-bit height.
    localparam int DIV_SHIFT = HEIGHT_BITS + $clog2(NUM_WINDOWS);
    localparam int PROD_BITS = HEIGHT_BITS + DIV_SHIFT;
    localparam logic [DIV_SHIFT-1:0] DIV_MULT = DIV_SHIFT'(
        ((longint'(1) << DIV_SHIFT) + longint'(NUM_WINDOWS) - 1) / longint'(NUM_WINDOWS));

    t_cfg                   r_cfg;
    logic [HEIGHT_BITS-1:0] r_band_height;
    logic [PROD_BITS-1:0]   height_prod;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width     <= IMAGE_WIDTH_RST;
            r_cfg.image_height    <= IMAGE_HEIGHT_RST;
            r_cfg.search_width    <= WINDOW_WIDTH_RST;
            r_cfg.count_threshold <= COUNT_THRESHOLD_RST;
            r_cfg.right_default   <= RIGHT_DEFAULT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                CFG_IMAGE_WIDTH:     r_cfg.image_width     <= i_cfg.data.value;
                CFG_IMAGE_HEIGHT:    r_cfg.image_height    <= i_cfg.data.value;
                CFG_WINDOW_WIDTH:    r_cfg.search_width    <= i_cfg.data.value[WINDOW_BITS-1:0];
                CFG_COUNT_THRESHOLD: r_cfg.count_threshold <= i_cfg.data.value[THRESH_BITS-1:0];
                CFG_RIGHT_DEFAULT:   r_cfg.right_default   <= i_cfg.data.value;
                default: begin
                end
            endcase
        end
    end

    assign height_prod = {{DIV_SHIFT{1'b0}}, r_cfg.image_height}
                       * {{HEIGHT_BITS{1'b0}}, DIV_MULT};

    // Follows image_height in the next cycle.
    always_ff @(posedge i_clk) begin
        r_band_height <= height_prod[DIV_SHIFT +: HEIGHT_BITS];
    end

    assign o_cfg         = r_cfg;
    assign o_band_height = r_band_height;

endmodule

FILE: rtl/swlt_side_acc.sv
// Row accumulator of one lane side: window or half test, first and last lit
// column, found flag, saturating count, seed midpoint. Depends on swlt_pkg.
module swlt_side_acc #(
    parameter int COORD_BITS = swlt_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  swlt_pkg::t_acc_ctl                  i_ctl,
    input  logic [COORD_BITS-1:0]               i_x,
    input  logic signed [COORD_BITS-1:0]        i_center,
    input  logic [swlt_pkg::MARGIN_BITS-1:0]    i_margin,
    input  logic [swlt_pkg::THRESH_BITS-1:0]    i_threshold,
    output swlt_pkg::t_side_stat                o_stat,
    output logic signed [COORD_BITS-1:0]        o_seed
);
    import swlt_pkg::*;

    localparam int WW = ((COORD_BITS > MARGIN_BITS) ? COORD_BITS : MARGIN_BITS) + 2;
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    logic [COORD_BITS-1:0] r_first, r_last;
    logic                  r_found;
    logic [COUNT_BITS-1:0] r_count;

    logic [COORD_BITS-1:0] base_first, base_last, n_first, n_last;
    logic                  base_found, n_found;
    logic [COUNT_BITS-1:0] base_count, n_count;
    logic signed [WW-1:0]  x_w, lo_w, hi_w;
    logic                  in_win, take;
    logic [COORD_BITS:0]   sum;
    logic [COORD_BITS-1:0] mid_u;
    logic [COUNT_BITS-1:0] thr_w;

    always_comb begin
        base_first = i_ctl.clear ? '0 : r_first;
        base_last  = i_ctl.clear ? '0 : r_last;
        base_found = i_ctl.clear ? 1'b0 : r_found;
        base_count = i_ctl.clear ? '0 : r_count;

        // Window covers [centre - margin, centre + margin).
        x_w    = signed'(WW'(i_x));
        lo_w   = WW'(i_center) - signed'(WW'(i_margin));
        hi_w   = WW'(i_center) + signed'(WW'(i_margin));
        in_win = (x_w >= lo_w) && (x_w < hi_w);
        take   = i_ctl.pixel && (i_ctl.init_row ? i_ctl.half_hit : in_win);

        n_first = (take && !base_found) ? i_x : base_first;
        n_last  = take ? i_x : base_last;
        n_found = base_found || take;
        n_count = (take && (base_count != COUNT_MAX)) ? base_count + 1'b1 : base_count;

        sum    = {1'b0, n_first} + {1'b0, n_last};
        mid_u  = sum[COORD_BITS:1];
        o_seed = mid_u[COORD_BITS-1] ? COORD_MAX : signed'(mid_u);

        thr_w        = COUNT_BITS'(i_threshold);
        o_stat.found = n_found;
        o_stat.move  = n_found && (n_count >= thr_w);
        o_stat.below = n_count < thr_w;
        o_stat.above = n_count > thr_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_last  <= '0;
            r_found <= 1'b0;
            r_count <= '0;
        end else if (i_ctl.advance) begin
            if (i_ctl.row_done) begin
                r_first <= '0;
                r_last  <= '0;
                r_found <= 1'b0;
                r_count <= '0;
            end else begin
                r_first <= n_first;
                r_last  <= n_last;
                r_found <= n_found;
                r_count <= n_count;
            end
        end
    end

endmodule

FILE: rtl/swlt_center_upd.sv
// End-of-row centre update: seeding, threshold moves, lane middle and
// mirroring of a weak side. Combinational. Depends on swlt_pkg.
module swlt_center_upd #(
    parameter int COORD_BITS = swlt_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_init_row,
    input  swlt_pkg::t_side_stat                 i_lstat,
    input  swlt_pkg::t_side_stat                 i_rstat,
    input  logic signed [COORD_BITS-1:0]         i_lseed,
    input  logic signed [COORD_BITS-1:0]         i_rseed,
    input  logic signed [COORD_BITS-1:0]         i_left_center,
    input  logic signed [COORD_BITS-1:0]         i_right_center,
    input  logic [swlt_pkg::DEFAULT_BITS-1:0]    i_right_default,
    output logic signed [COORD_BITS-1:0]         o_left,
    output logic signed [COORD_BITS-1:0]         o_right,
    output logic signed [COORD_BITS-1:0]         o_mid
);
    import swlt_pkg::*;

    localparam int SW = ((COORD_BITS > DEFAULT_BITS) ? COORD_BITS : DEFAULT_BITS) + 3;
    localparam logic signed [SW-1:0] MAX_W = SW'((longint'(1) << (COORD_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] MIN_W = -MAX_W - SW'(1);

    function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [SW-1:0] v);
        logic signed [COORD_BITS-1:0] r;
        if (v > MAX_W) begin
            r = MAX_W[COORD_BITS-1:0];
        end else if (v < MIN_W) begin
            r = MIN_W[COORD_BITS-1:0];
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    logic signed [COORD_BITS-1:0] lc0, rc0, mid;
    logic signed [SW-1:0]         sum_w, adj_w, mid_w;

    always_comb begin
        if (i_init_row) begin
            lc0 = i_lstat.found ? i_lseed : '0;
            rc0 = i_rstat.found ? i_rseed : sat_coord(signed'(SW'(i_right_default)));
        end else begin
            lc0 = i_lstat.move ? i_lseed : i_left_center;
            rc0 = i_rstat.move ? i_rseed : i_right_center;
        end

        // Middle rounds toward zero.
        sum_w = SW'(lc0) + SW'(rc0);
        adj_w = sum_w + signed'(SW'(sum_w[SW-1]));
        mid_w = adj_w >>> 1;
        mid   = mid_w[COORD_BITS-1:0];

        o_left  = lc0;
        o_right = rc0;
        if (!i_init_row) begin
            if (i_lstat.below && i_rstat.above) begin
                o_left = sat_coord((SW'(mid) <<< 1) - SW'(rc0));
            end else if (i_lstat.above && i_rstat.below) begin
                o_right = sat_coord((SW'(mid) <<< 1) - SW'(lc0));
            end
        end
        o_mid = mid;
    end

endmodule
